// ===== rtl/lpc_pkg.sv =====
`default_nettype none

package lpc_pkg;

   // Request codes
   localparam logic [2:0] OP_PUT    = 3'd0;
   localparam logic [2:0] OP_GET    = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_TICK   = 3'd3;
   localparam logic [2:0] OP_SWEEP  = 3'd4;

   // Result status codes
   localparam logic [3:0] ST_UPDATED   = 4'd0;
   localparam logic [3:0] ST_INSERTED  = 4'd1;
   localparam logic [3:0] ST_EVICTED   = 4'd2;
   localparam logic [3:0] ST_HIT       = 4'd3;
   localparam logic [3:0] ST_MISS      = 4'd4;
   localparam logic [3:0] ST_DELETED   = 4'd5;
   localparam logic [3:0] ST_ABSENT    = 4'd6;
   localparam logic [3:0] ST_TICKED    = 4'd7;
   localparam logic [3:0] ST_AGED      = 4'd8;
   localparam logic [3:0] ST_NONE_AGED = 4'd9;
   localparam logic [3:0] ST_BAD_KEY   = 4'd10;
   localparam logic [3:0] ST_BAD_SIGMA = 4'd11;

   // Configuration register indexes
   localparam logic [1:0] REG_TRUST = 2'd0;
   localparam logic [1:0] REG_LONG  = 2'd1;
   localparam logic [1:0] REG_SHORT = 2'd2;

   localparam logic [9:0]  TRUST_RESET = 10'd300;
   localparam logic [31:0] LONG_RESET  = 32'd100;
   localparam logic [31:0] SHORT_RESET = 32'd10;
   localparam logic [9:0]  SIGMA_MAX   = 10'd1000;
   localparam logic [15:0] USES_MAX    = 16'hFFFF;
   localparam int          SCORE_W     = 38;

   // Datapath micro-operations
   localparam logic [4:0] UOP_NOP          = 5'd0;
   localparam logic [4:0] UOP_ACCEPT       = 5'd1;
   localparam logic [4:0] UOP_READ_IDX     = 5'd2;
   localparam logic [4:0] UOP_PROBE_NEXT   = 5'd3;
   localparam logic [4:0] UOP_WRITE_UPDATE = 5'd4;
   localparam logic [4:0] UOP_WRITE_HIT    = 5'd5;
   localparam logic [4:0] UOP_WRITE_INSERT = 5'd6;
   localparam logic [4:0] UOP_VSTART       = 5'd7;
   localparam logic [4:0] UOP_READ_SCAN    = 5'd8;
   localparam logic [4:0] UOP_SCORE        = 5'd9;
   localparam logic [4:0] UOP_VCMP         = 5'd10;
   localparam logic [4:0] UOP_RM_START     = 5'd11;
   localparam logic [4:0] UOP_READ_J       = 5'd12;
   localparam logic [4:0] UOP_RM_HOME      = 5'd13;
   localparam logic [4:0] UOP_MV_WRITE     = 5'd14;
   localparam logic [4:0] UOP_HOME_KEY     = 5'd15;
   localparam logic [4:0] UOP_TICK         = 5'd16;
   localparam logic [4:0] UOP_SCAN_NEXT    = 5'd17;
   localparam logic [4:0] UOP_HOLD         = 5'd18;

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] payload;
      logic [9:0]  sigma;
      logic [15:0] uses;
      logic [31:0] last_step;
   } entry_type;

   typedef struct packed {
      logic [4:0] uop;
      logic       rsp_load;
      logic [3:0] rsp_code;
      logic       rsp_last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       key_zero;
      logic       sigma_bad;
      logic       valid_idx;
      logic       valid_j;
      logic       valid_scan;
      logic       key_match;
      logic       probe_last;
      logic       vscan_last;
      logic       rm_done;
      logic       scan_end;
      logic       expired;
      logic       held_valid;
      logic       rsp_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/lpc_ctrl.sv =====
`default_nettype none

module lpc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire lpc_pkg::status_type sts,
   output lpc_pkg::cmd_type        cmd
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DISP   = 5'd1;
   localparam logic [4:0] S_F_CHK  = 5'd2;
   localparam logic [4:0] S_F_CMP  = 5'd3;
   localparam logic [4:0] S_V_RD   = 5'd4;
   localparam logic [4:0] S_V_SC   = 5'd5;
   localparam logic [4:0] S_V_CMP  = 5'd6;
   localparam logic [4:0] S_R_STRT = 5'd7;
   localparam logic [4:0] S_R_CHK  = 5'd8;
   localparam logic [4:0] S_R_MV   = 5'd9;
   localparam logic [4:0] S_R_FND  = 5'd10;
   localparam logic [4:0] S_E_HOME = 5'd11;
   localparam logic [4:0] S_E_CHK  = 5'd12;
   localparam logic [4:0] S_W_CHK  = 5'd13;
   localparam logic [4:0] S_W_EV   = 5'd14;
   localparam logic [4:0] S_W_PUSH = 5'd15;
   localparam logic [4:0] S_RESP   = 5'd16;

   logic [4:0] state_ff, state_in;
   logic [3:0] code_ff, code_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      cmd.uop      = lpc_pkg::UOP_NOP;
      cmd.rsp_load = 1'b0;
      cmd.rsp_code = code_ff;
      cmd.rsp_last = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.uop  = lpc_pkg::UOP_ACCEPT;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (sts.op <= lpc_pkg::OP_DELETE && sts.key_zero) begin
               code_in  = lpc_pkg::ST_BAD_KEY;
               state_in = S_RESP;
            end else if (sts.op == lpc_pkg::OP_PUT && sts.sigma_bad) begin
               code_in  = lpc_pkg::ST_BAD_SIGMA;
               state_in = S_RESP;
            end else if (sts.op <= lpc_pkg::OP_DELETE) begin
               state_in = S_F_CHK;
            end else if (sts.op == lpc_pkg::OP_TICK) begin
               cmd.uop  = lpc_pkg::UOP_TICK;
               code_in  = lpc_pkg::ST_TICKED;
               state_in = S_RESP;
            end else if (sts.op == lpc_pkg::OP_SWEEP) begin
               state_in = S_W_CHK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_F_CHK: begin
            if (sts.valid_idx) begin
               cmd.uop  = lpc_pkg::UOP_READ_IDX;
               state_in = S_F_CMP;
            end else begin
               state_in = S_RESP;
               case (sts.op)
                  lpc_pkg::OP_PUT: begin
                     cmd.uop = lpc_pkg::UOP_WRITE_INSERT;
                     code_in = lpc_pkg::ST_INSERTED;
                  end
                  lpc_pkg::OP_GET: code_in = lpc_pkg::ST_MISS;
                  default:         code_in = lpc_pkg::ST_ABSENT;
               endcase
            end
         end
         S_F_CMP: begin
            if (sts.key_match) begin
               case (sts.op)
                  lpc_pkg::OP_PUT: begin
                     cmd.uop  = lpc_pkg::UOP_WRITE_UPDATE;
                     code_in  = lpc_pkg::ST_UPDATED;
                     state_in = S_RESP;
                  end
                  lpc_pkg::OP_GET: begin
                     cmd.uop  = lpc_pkg::UOP_WRITE_HIT;
                     code_in  = lpc_pkg::ST_HIT;
                     state_in = S_RESP;
                  end
                  default: state_in = S_R_STRT;
               endcase
            end else if (sts.probe_last) begin
               case (sts.op)
                  lpc_pkg::OP_PUT: begin
                     cmd.uop  = lpc_pkg::UOP_VSTART;
                     state_in = S_V_RD;
                  end
                  lpc_pkg::OP_GET: begin
                     code_in  = lpc_pkg::ST_MISS;
                     state_in = S_RESP;
                  end
                  default: begin
                     code_in  = lpc_pkg::ST_ABSENT;
                     state_in = S_RESP;
                  end
               endcase
            end else begin
               cmd.uop  = lpc_pkg::UOP_PROBE_NEXT;
               state_in = S_F_CHK;
            end
         end
         S_V_RD: begin
            cmd.uop  = lpc_pkg::UOP_READ_SCAN;
            state_in = S_V_SC;
         end
         S_V_SC: begin
            cmd.uop  = lpc_pkg::UOP_SCORE;
            state_in = S_V_CMP;
         end
         S_V_CMP: begin
            cmd.uop  = lpc_pkg::UOP_VCMP;
            state_in = sts.vscan_last ? S_R_STRT : S_V_RD;
         end
         S_R_STRT: begin
            cmd.uop  = lpc_pkg::UOP_RM_START;
            state_in = S_R_CHK;
         end
         S_R_CHK: begin
            if (sts.rm_done || !sts.valid_j) begin
               // The cluster is rebuilt; carry on with what asked for the removal.
               case (sts.op)
                  lpc_pkg::OP_PUT: state_in = S_E_HOME;
                  lpc_pkg::OP_DELETE: begin
                     code_in  = lpc_pkg::ST_DELETED;
                     state_in = S_RESP;
                  end
                  default: state_in = S_W_CHK;
               endcase
            end else begin
               cmd.uop  = lpc_pkg::UOP_READ_J;
               state_in = S_R_MV;
            end
         end
         S_R_MV: begin
            cmd.uop  = lpc_pkg::UOP_RM_HOME;
            state_in = S_R_FND;
         end
         S_R_FND: begin
            if (sts.valid_idx) begin
               cmd.uop = lpc_pkg::UOP_PROBE_NEXT;
            end else begin
               cmd.uop  = lpc_pkg::UOP_MV_WRITE;
               state_in = S_R_CHK;
            end
         end
         S_E_HOME: begin
            cmd.uop  = lpc_pkg::UOP_HOME_KEY;
            state_in = S_E_CHK;
         end
         S_E_CHK: begin
            if (sts.valid_idx) begin
               cmd.uop = lpc_pkg::UOP_PROBE_NEXT;
            end else begin
               cmd.uop  = lpc_pkg::UOP_WRITE_INSERT;
               code_in  = lpc_pkg::ST_EVICTED;
               state_in = S_RESP;
            end
         end
         S_W_CHK: begin
            if (sts.scan_end) begin
               code_in  = sts.held_valid ? lpc_pkg::ST_AGED : lpc_pkg::ST_NONE_AGED;
               state_in = S_RESP;
            end else if (!sts.valid_scan) begin
               cmd.uop = lpc_pkg::UOP_SCAN_NEXT;
            end else begin
               cmd.uop  = lpc_pkg::UOP_READ_SCAN;
               state_in = S_W_EV;
            end
         end
         S_W_EV: begin
            if (!sts.expired) begin
               cmd.uop  = lpc_pkg::UOP_SCAN_NEXT;
               state_in = S_W_CHK;
            end else if (sts.held_valid) begin
               state_in = S_W_PUSH;
            end else begin
               cmd.uop  = lpc_pkg::UOP_HOLD;
               state_in = S_R_STRT;
            end
         end
         S_W_PUSH: begin
            // The held item is not the last one, since another entry expired.
            if (sts.rsp_free) begin
               cmd.uop      = lpc_pkg::UOP_HOLD;
               cmd.rsp_load = 1'b1;
               cmd.rsp_code = lpc_pkg::ST_AGED;
               cmd.rsp_last = 1'b0;
               state_in     = S_R_STRT;
            end
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= lpc_pkg::ST_UPDATED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   property p_accept_only_idle;
      @(posedge clock) disable iff (reset)
         (cmd.uop == lpc_pkg::UOP_ACCEPT) |-> (state_ff == S_IDLE && req_valid);
   endproperty
   a_accept_only_idle: assert property (p_accept_only_idle)
      else $error("item taken outside idle");

   property p_resp_returns_idle;
      @(posedge clock) disable iff (reset)
         (state_ff == S_RESP && cmd.rsp_load) |=> (state_ff == S_IDLE);
   endproperty
   a_resp_returns_idle: assert property (p_resp_returns_idle)
      else $error("final result did not end the request");

   property p_push_not_last;
      @(posedge clock) disable iff (reset)
         (cmd.rsp_load && !cmd.rsp_last) |-> (cmd.rsp_code == lpc_pkg::ST_AGED);
   endproperty
   a_push_not_last: assert property (p_push_not_last)
      else $error("non-final result with a status other than aged");

endmodule

`default_nettype wire

// ===== rtl/lpc_datapath.sv =====
`default_nettype none

module lpc_datapath #(
   parameter int SLOTS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [2:0]         req_type,
   input  wire logic [63:0]        req_key,
   input  wire logic [9:0]         req_sigma_milli,
   input  wire logic [31:0]        req_payload,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_wr_data,
   input  wire lpc_pkg::cmd_type   cmd,
   output lpc_pkg::status_type     sts,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_status,
   output logic [63:0]             rsp_out_key,
   output logic [31:0]             rsp_out_payload,
   output logic [9:0]              rsp_out_sigma,
   output logic [15:0]             rsp_out_uses,
   output logic [31:0]             rsp_out_last_step,
   output logic [6:0]              rsp_freed_count,
   output logic                    rsp_last
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = AW + 1;

   // Slot storage: keys and attributes live in one memory, occupancy in flops.
   lpc_pkg::entry_type slot_mem [SLOTS];
   lpc_pkg::entry_type rd_ff;
   logic [SLOTS-1:0]   valid_ff;

   logic [2:0]  op_ff;
   logic [63:0] key_ff;
   logic [9:0]  sigma_ff;
   logic [31:0] payload_ff;
   logic [31:0] step_ff;
   logic [9:0]  thr_ff;
   logic [31:0] long_ff;
   logic [31:0] short_ff;

   logic [AW-1:0] idx_ff;
   logic [CW-1:0] cnt_ff;
   logic [AW-1:0] j_ff;
   logic [CW-1:0] rn_ff;
   logic [CW-1:0] scan_ff;
   logic [CW-1:0] freed_ff;

   logic                      best_any_ff;
   logic [AW-1:0]             best_idx_ff;
   logic [63:0]               best_key_ff;
   logic signed [lpc_pkg::SCORE_W-1:0] top_score_ff;
   logic signed [lpc_pkg::SCORE_W-1:0] score_ff, score_in;

   logic          held_valid_ff;
   logic [63:0]   held_key_ff;
   logic [31:0]   held_payload_ff;
   logic [CW-1:0] held_freed_ff;

   logic          rsp_valid_ff;
   logic [3:0]    rsp_status_ff;
   logic [63:0]   rsp_key_ff;
   logic [31:0]   rsp_payload_ff;
   logic [9:0]    rsp_sigma_ff;
   logic [15:0]   rsp_uses_ff;
   logic [31:0]   rsp_step_ff;
   logic [6:0]    rsp_freed_ff;
   logic          rsp_last_ff;

   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   lpc_pkg::entry_type   mem_wd;
   logic                 mem_re;
   logic [AW-1:0]        mem_ra;

   logic [31:0]   age;
   logic [31:0]   life;
   logic [15:0]   uses_inc;
   logic [AW-1:0] rm_src;
   logic [35:0]   age10;
   logic [22:0]   uses100;
   logic          rsp_free;

   assign age      = (step_ff > rd_ff.last_step) ? step_ff - rd_ff.last_step : 32'd0;
   assign life     = (rd_ff.sigma <= thr_ff) ? long_ff : short_ff;
   assign uses_inc = (rd_ff.uses == lpc_pkg::USES_MAX) ? rd_ff.uses : rd_ff.uses + 16'd1;
   assign age10    = {1'b0, age, 3'b000} + {3'b000, age, 1'b0};
   assign uses100  = {1'b0, rd_ff.uses, 6'b0} + {2'b0, rd_ff.uses, 5'b0}
                   + {5'b0, rd_ff.uses, 2'b0};
   assign score_in = lpc_pkg::SCORE_W'({28'b0, rd_ff.sigma})
                   + lpc_pkg::SCORE_W'(age10) - lpc_pkg::SCORE_W'(uses100);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (op_ff)
         lpc_pkg::OP_PUT:    rm_src = best_idx_ff;
         lpc_pkg::OP_DELETE: rm_src = idx_ff;
         default:            rm_src = scan_ff[AW-1:0];
      endcase
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = idx_ff;
      mem_wd = rd_ff;
      mem_re = 1'b0;
      mem_ra = idx_ff;
      case (cmd.uop)
         lpc_pkg::UOP_WRITE_UPDATE: begin
            mem_we = 1'b1;
            mem_wd = '{key: key_ff, payload: payload_ff, sigma: sigma_ff,
                       uses: rd_ff.uses, last_step: step_ff};
         end
         lpc_pkg::UOP_WRITE_HIT: begin
            mem_we = 1'b1;
            mem_wd = '{key: rd_ff.key, payload: rd_ff.payload, sigma: rd_ff.sigma,
                       uses: uses_inc, last_step: step_ff};
         end
         lpc_pkg::UOP_WRITE_INSERT: begin
            mem_we = 1'b1;
            mem_wd = '{key: key_ff, payload: payload_ff, sigma: sigma_ff,
                       uses: 16'd0, last_step: step_ff};
         end
         lpc_pkg::UOP_MV_WRITE: mem_we = 1'b1;
         lpc_pkg::UOP_READ_IDX: mem_re = 1'b1;
         lpc_pkg::UOP_READ_SCAN: begin
            mem_re = 1'b1;
            mem_ra = scan_ff[AW-1:0];
         end
         lpc_pkg::UOP_READ_J: begin
            mem_re = 1'b1;
            mem_ra = j_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= slot_mem[mem_ra];
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= 32'd0;
         thr_ff        <= lpc_pkg::TRUST_RESET;
         long_ff       <= lpc_pkg::LONG_RESET;
         short_ff      <= lpc_pkg::SHORT_RESET;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               lpc_pkg::REG_TRUST: thr_ff   <= csr_wr_data[9:0];
               lpc_pkg::REG_LONG:  long_ff  <= csr_wr_data;
               lpc_pkg::REG_SHORT: short_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.uop)
            lpc_pkg::UOP_ACCEPT:       held_valid_ff    <= 1'b0;
            lpc_pkg::UOP_HOLD:         held_valid_ff    <= 1'b1;
            lpc_pkg::UOP_TICK:         step_ff          <= step_ff + 32'd1;
            lpc_pkg::UOP_WRITE_INSERT: valid_ff[idx_ff] <= 1'b1;
            lpc_pkg::UOP_MV_WRITE:     valid_ff[idx_ff] <= 1'b1;
            lpc_pkg::UOP_RM_START:     valid_ff[rm_src] <= 1'b0;
            lpc_pkg::UOP_READ_J:       valid_ff[j_ff]   <= 1'b0;
            default: ;
         endcase
      end
   end

   // Working registers of the walks and scans.
   always_ff @(posedge clock) begin
      case (cmd.uop)
         lpc_pkg::UOP_ACCEPT: begin
            op_ff      <= req_type;
            key_ff     <= req_key;
            sigma_ff   <= req_sigma_milli;
            payload_ff <= req_payload;
            idx_ff     <= req_key[AW-1:0];
            cnt_ff     <= '0;
            scan_ff    <= '0;
            freed_ff   <= '0;
         end
         lpc_pkg::UOP_PROBE_NEXT: begin
            idx_ff <= idx_ff + AW'(1);
            cnt_ff <= cnt_ff + CW'(1);
         end
         lpc_pkg::UOP_VSTART: begin
            scan_ff     <= '0;
            best_any_ff <= 1'b0;
         end
         lpc_pkg::UOP_SCORE: score_ff <= score_in;
         lpc_pkg::UOP_VCMP: begin
            // Strictly greater keeps the lowest index on a tie.
            if (!best_any_ff || score_ff > top_score_ff) begin
               best_any_ff  <= 1'b1;
               top_score_ff <= score_ff;
               best_idx_ff  <= scan_ff[AW-1:0];
               best_key_ff  <= rd_ff.key;
            end
            scan_ff <= scan_ff + CW'(1);
         end
         lpc_pkg::UOP_RM_START: begin
            j_ff  <= rm_src + AW'(1);
            rn_ff <= '0;
         end
         lpc_pkg::UOP_RM_HOME:  idx_ff <= rd_ff.key[AW-1:0];
         lpc_pkg::UOP_MV_WRITE: begin
            j_ff  <= j_ff + AW'(1);
            rn_ff <= rn_ff + CW'(1);
         end
         lpc_pkg::UOP_HOME_KEY: begin
            idx_ff <= key_ff[AW-1:0];
            cnt_ff <= '0;
         end
         lpc_pkg::UOP_SCAN_NEXT: scan_ff <= scan_ff + CW'(1);
         lpc_pkg::UOP_HOLD: begin
            held_key_ff     <= rd_ff.key;
            held_payload_ff <= rd_ff.payload;
            held_freed_ff   <= freed_ff + CW'(1);
            freed_ff        <= freed_ff + CW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff  <= cmd.rsp_code;
         rsp_last_ff    <= cmd.rsp_last;
         rsp_key_ff     <= 64'd0;
         rsp_payload_ff <= 32'd0;
         rsp_sigma_ff   <= 10'd0;
         rsp_uses_ff    <= 16'd0;
         rsp_step_ff    <= 32'd0;
         rsp_freed_ff   <= 7'd0;
         case (cmd.rsp_code)
            lpc_pkg::ST_HIT: begin
               rsp_payload_ff <= rd_ff.payload;
               rsp_sigma_ff   <= rd_ff.sigma;
               rsp_uses_ff    <= uses_inc;
               rsp_step_ff    <= step_ff;
            end
            lpc_pkg::ST_EVICTED: rsp_key_ff <= best_key_ff;
            lpc_pkg::ST_AGED: begin
               rsp_key_ff     <= held_key_ff;
               rsp_payload_ff <= held_payload_ff;
               rsp_freed_ff   <= 7'(held_freed_ff);
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_key       = rsp_key_ff;
   assign rsp_out_payload   = rsp_payload_ff;
   assign rsp_out_sigma     = rsp_sigma_ff;
   assign rsp_out_uses      = rsp_uses_ff;
   assign rsp_out_last_step = rsp_step_ff;
   assign rsp_freed_count   = rsp_freed_ff;
   assign rsp_last          = rsp_last_ff;

   assign sts.op         = op_ff;
   assign sts.key_zero   = (key_ff == 64'd0);
   assign sts.sigma_bad  = (sigma_ff > lpc_pkg::SIGMA_MAX);
   assign sts.valid_idx  = valid_ff[idx_ff];
   assign sts.valid_j    = valid_ff[j_ff];
   assign sts.valid_scan = valid_ff[scan_ff[AW-1:0]];
   assign sts.key_match  = (rd_ff.key == key_ff);
   assign sts.probe_last = (cnt_ff == CW'(SLOTS - 1));
   assign sts.vscan_last = (scan_ff == CW'(SLOTS - 1));
   assign sts.rm_done    = (rn_ff == CW'(SLOTS));
   assign sts.scan_end   = (scan_ff == CW'(SLOTS)) || (freed_ff == CW'(SLOTS));
   assign sts.expired    = (age > life);
   assign sts.held_valid = held_valid_ff;
   assign sts.rsp_free   = rsp_free;

   property p_insert_into_empty;
      @(posedge clock) disable iff (reset)
         (cmd.uop == lpc_pkg::UOP_WRITE_INSERT || cmd.uop == lpc_pkg::UOP_MV_WRITE)
            |-> !valid_ff[idx_ff];
   endproperty
   a_insert_into_empty: assert property (p_insert_into_empty)
      else $error("entry written over an occupied slot");

   property p_remove_occupied;
      @(posedge clock) disable iff (reset)
         (cmd.uop == lpc_pkg::UOP_RM_START) |-> valid_ff[rm_src];
   endproperty
   a_remove_occupied: assert property (p_remove_occupied)
      else $error("removal of an empty slot");

   property p_held_counted;
      @(posedge clock) disable iff (reset)
         held_valid_ff |-> (freed_ff != '0 && held_freed_ff == freed_ff);
   endproperty
   a_held_counted: assert property (p_held_counted)
      else $error("held aged item out of step with the freed count");

   property p_load_when_free;
      @(posedge clock) disable iff (reset)
         cmd.rsp_load |-> rsp_free;
   endproperty
   a_load_when_free: assert property (p_load_when_free)
      else $error("result register overwritten while still stalled");

endmodule

`default_nettype wire

// ===== rtl/linear_probe_cache_with_ttl_core.sv =====
`default_nettype none

// Linear-probing key cache of SLOTS entries with confidence-dependent lifetime.
// One item is handled at a time; a new item is taken as soon as the previous
// one has placed its last result in the output register; an unused request
// type gives no result and frees the core once dispatched. Cost is set by the
// single-port slot memory, read once per probed slot: a lookup reads each
// probed slot in turn; a put into a full table adds a victim scan over all
// SLOTS entries plus the removal; a removal re-places each following entry of
// the cluster, walking slots from its home to find a free one; a sweep reads
// each live slot, skips empty ones, removes aged-out entries with one result
// each, or one none-aged result. No clearing pass is needed after reset.

module linear_probe_cache_with_ttl_core #(
   parameter int SLOTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [63:0] req_key,
   input  wire logic [9:0]  req_sigma_milli,
   input  wire logic [31:0] req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_status,
   output logic [63:0]      rsp_out_key,
   output logic [31:0]      rsp_out_payload,
   output logic [9:0]       rsp_out_sigma,
   output logic [15:0]      rsp_out_uses,
   output logic [31:0]      rsp_out_last_step,
   output logic [6:0]       rsp_freed_count,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);

   lpc_pkg::cmd_type    cmd;
   lpc_pkg::status_type sts;

   lpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpc_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_key           (req_key),
      .req_sigma_milli   (req_sigma_milli),
      .req_payload       (req_payload),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_payload   (rsp_out_payload),
      .rsp_out_sigma     (rsp_out_sigma),
      .rsp_out_uses      (rsp_out_uses),
      .rsp_out_last_step (rsp_out_last_step),
      .rsp_freed_count   (rsp_freed_count),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOTS = 64;
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
   localparam logic [2:0] OP_RSVD_LAST = 3'd7;
   localparam int SETTLE_CYCLES = 6000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [3:0]  status;
      logic [63:0] key;
      logic [31:0] payload;
      logic [9:0]  sigma;
      logic [15:0] uses;
      logic [31:0] last_step;
      logic [6:0]  freed;
      logic        last;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type = lpc_pkg::OP_TICK;
   logic [63:0] req_key = '0;
   logic [9:0]  req_sigma_milli = '0;
   logic [31:0] req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [63:0] rsp_out_key;
   logic [31:0] rsp_out_payload;
   logic [9:0]  rsp_out_sigma;
   logic [15:0] rsp_out_uses;
   logic [31:0] rsp_out_last_step;
   logic [6:0]  rsp_freed_count;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = lpc_pkg::REG_TRUST;
   logic [31:0] csr_wr_data = '0;

   linear_probe_cache_with_ttl_core #(.SLOTS(NSLOTS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_key(req_key), .req_sigma_milli(req_sigma_milli), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_out_key(rsp_out_key), .rsp_out_payload(rsp_out_payload),
      .rsp_out_sigma(rsp_out_sigma), .rsp_out_uses(rsp_out_uses),
      .rsp_out_last_step(rsp_out_last_step), .rsp_freed_count(rsp_freed_count),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Shadow copy of the cache contents and registers.
   logic [63:0] tbl_key[NSLOTS];
   logic [31:0] tbl_payload[NSLOTS];
   logic [9:0]  tbl_sigma[NSLOTS];
   logic [15:0] tbl_uses[NSLOTS];
   logic [31:0] tbl_last[NSLOTS];
   logic [31:0] step_now;
   logic [9:0]  trust_lim;
   logic [31:0] life_long;
   logic [31:0] life_short;

   result_type pending_results[$];
   logic [63:0] key_pool[96];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   bit idle_on = 1'b1;
   bit pressure_on = 1'b0;
   int hold_count = 0;

   function automatic void clear_entry(input int i);
      tbl_key[i] = '0;
      tbl_payload[i] = '0;
      tbl_sigma[i] = '0;
      tbl_uses[i] = '0;
      tbl_last[i] = '0;
   endfunction

   function automatic int locate(input logic [63:0] k, output bit hit);
      int i;
      i = int'(k[5:0]);
      hit = 1'b0;
      for (int n = 0; n < NSLOTS; n++) begin
         if (tbl_key[i] == '0) return i;
         if (tbl_key[i] == k) begin
            hit = 1'b1;
            return i;
         end
         i = (i + 1) % NSLOTS;
      end
      return NSLOTS;
   endfunction

   function automatic logic [31:0] age_of(input int i);
      return (step_now > tbl_last[i]) ? step_now - tbl_last[i] : 32'd0;
   endfunction

   // Empty slot i, then re-place the rest of its cluster.
   function automatic void evacuate(input int i);
      int j;
      int d;
      bit f;
      logic [63:0] mk;
      logic [31:0] mp, ml;
      logic [9:0]  ms;
      logic [15:0] mu;
      j = (i + 1) % NSLOTS;
      clear_entry(i);
      for (int n = 0; n < NSLOTS && tbl_key[j] != '0; n++) begin
         mk = tbl_key[j]; mp = tbl_payload[j]; ms = tbl_sigma[j];
         mu = tbl_uses[j]; ml = tbl_last[j];
         clear_entry(j);
         d = locate(mk, f);
         if (d >= NSLOTS) d = j;
         tbl_key[d] = mk; tbl_payload[d] = mp; tbl_sigma[d] = ms;
         tbl_uses[d] = mu; tbl_last[d] = ml;
         j = (j + 1) % NSLOTS;
      end
   endfunction

   function automatic int choose_evictee();
      int best;
      bit any;
      longint top_score, s;
      best = 0;
      any = 1'b0;
      top_score = 0;
      for (int i = 0; i < NSLOTS; i++) begin
         if (tbl_key[i] == '0) continue;
         s = longint'(tbl_sigma[i]) + 10 * longint'(age_of(i)) - 100 * longint'(tbl_uses[i]);
         if (!any || s > top_score) begin
            any = 1'b1;
            top_score = s;
            best = i;
         end
      end
      return best;
   endfunction

   function automatic void add_result(input logic [3:0] st, input logic [63:0] k,
                                      input logic [31:0] p, input logic [9:0] sg,
                                      input logic [15:0] u, input logic [31:0] ls,
                                      input logic [6:0] fr, input logic lst);
      result_type r;
      r.status = st; r.key = k; r.payload = p; r.sigma = sg;
      r.uses = u; r.last_step = ls; r.freed = fr; r.last = lst;
      pending_results.push_back(r);
   endfunction

   function automatic void predict_cache(input logic [2:0] op, input logic [63:0] k,
                                         input logic [9:0] sg, input logic [31:0] p);
      int idx, v, freed, i;
      bit hit;
      logic [63:0] evicted, ek;
      logic [31:0] life;
      if (op <= lpc_pkg::OP_DELETE && k == '0) begin
         add_result(lpc_pkg::ST_BAD_KEY, '0, '0, '0, '0, '0, '0, 1'b1);
         return;
      end
      case (op)
         lpc_pkg::OP_PUT: begin
            if (sg > lpc_pkg::SIGMA_MAX) begin
               add_result(lpc_pkg::ST_BAD_SIGMA, '0, '0, '0, '0, '0, '0, 1'b1);
               return;
            end
            idx = locate(k, hit);
            if (hit) begin
               tbl_sigma[idx] = sg; tbl_payload[idx] = p; tbl_last[idx] = step_now;
               add_result(lpc_pkg::ST_UPDATED, '0, '0, '0, '0, '0, '0, 1'b1);
               return;
            end
            evicted = '0;
            if (idx >= NSLOTS) begin
               v = choose_evictee();
               evicted = tbl_key[v];
               evacuate(v);
               idx = locate(k, hit);
               if (idx >= NSLOTS) idx = v;
            end
            tbl_key[idx] = k; tbl_sigma[idx] = sg; tbl_payload[idx] = p;
            tbl_uses[idx] = '0; tbl_last[idx] = step_now;
            add_result(evicted != '0 ? lpc_pkg::ST_EVICTED : lpc_pkg::ST_INSERTED, evicted,
                       '0, '0, '0, '0, '0, 1'b1);
         end
         lpc_pkg::OP_GET: begin
            idx = locate(k, hit);
            if (!hit) begin
               add_result(lpc_pkg::ST_MISS, '0, '0, '0, '0, '0, '0, 1'b1);
               return;
            end
            if (tbl_uses[idx] != lpc_pkg::USES_MAX) tbl_uses[idx]++;
            tbl_last[idx] = step_now;
            add_result(lpc_pkg::ST_HIT, '0, tbl_payload[idx], tbl_sigma[idx], tbl_uses[idx],
                       tbl_last[idx], '0, 1'b1);
         end
         lpc_pkg::OP_DELETE: begin
            idx = locate(k, hit);
            if (!hit) begin
               add_result(lpc_pkg::ST_ABSENT, '0, '0, '0, '0, '0, '0, 1'b1);
               return;
            end
            evacuate(idx);
            add_result(lpc_pkg::ST_DELETED, '0, '0, '0, '0, '0, '0, 1'b1);
         end
         lpc_pkg::OP_TICK: begin
            step_now++;
            add_result(lpc_pkg::ST_TICKED, '0, '0, '0, '0, '0, '0, 1'b1);
         end
         lpc_pkg::OP_SWEEP: begin
            i = 0;
            freed = 0;
            while (i < NSLOTS && freed < NSLOTS) begin
               if (tbl_key[i] == '0) begin
                  i++;
                  continue;
               end
               life = (tbl_sigma[i] <= trust_lim) ? life_long : life_short;
               if (age_of(i) > life) begin
                  ek = tbl_key[i];
                  p = tbl_payload[i];
                  evacuate(i);
                  freed++;
                  add_result(lpc_pkg::ST_AGED, ek, p, '0, '0, '0, 7'(freed), 1'b0);
               end else begin
                  i++;
               end
            end
            if (freed == 0) begin
               add_result(lpc_pkg::ST_NONE_AGED, '0, '0, '0, '0, '0, '0, 1'b1);
            end else begin
               pending_results[$].last = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   // Result side: the field checks.
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result with status %0d arrived with none expected", rsp_status);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status); errors++;
            end
            if (rsp_out_key !== e.key) begin
               $error("out_key: expected %h, got %h", e.key, rsp_out_key); errors++;
            end
            if (rsp_out_payload !== e.payload) begin
               $error("out_payload: expected %h, got %h", e.payload, rsp_out_payload);
               errors++;
            end
            if (rsp_out_sigma !== e.sigma) begin
               $error("out_sigma: expected %0d, got %0d", e.sigma, rsp_out_sigma); errors++;
            end
            if (rsp_out_uses !== e.uses) begin
               $error("out_uses: expected %0d, got %0d", e.uses, rsp_out_uses); errors++;
            end
            if (rsp_out_last_step !== e.last_step) begin
               $error("out_last_step: expected %0d, got %0d", e.last_step,
                      rsp_out_last_step);
               errors++;
            end
            if (rsp_freed_count !== e.freed) begin
               $error("freed_count: expected %0d, got %0d", e.freed, rsp_freed_count);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_last); errors++;
            end
         end
      end
   end

   // Result side stalls: random idling, and one long hold-off counted here.
   always @(posedge clock) begin
      if (pressure_on && hold_count < HOLD_CYCLES) begin
         hold_count++;
         rsp_stall <= 1'b1;
      end else if (idle_on) begin
         rsp_stall <= ($urandom_range(99) < 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offers one item and returns once it has been taken; valid stays high.
   task automatic send_item(input logic [2:0] op, input logic [63:0] k,
                            input logic [9:0] sg, input logic [31:0] p);
      while (idle_on && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_key <= k;
      req_sigma_milli <= sg;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cache(op, k, sg, p);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input logic [9:0] trust, input logic [31:0] lng,
                                  input logic [31:0] shrt);
      logic [31:0] spare;
      spare = $urandom;
      csr_wr_en <= 1'b1;
      csr_index <= lpc_pkg::REG_TRUST;
      csr_wr_data <= {spare[31:10], trust};
      @(posedge clock);
      csr_index <= lpc_pkg::REG_LONG;
      csr_wr_data <= lng;
      @(posedge clock);
      csr_index <= lpc_pkg::REG_SHORT;
      csr_wr_data <= shrt;
      @(posedge clock);
      // The unused index must leave every register alone.
      csr_index <= REG_UNUSED;
      csr_wr_data <= $urandom;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      trust_lim = trust;
      life_long = lng;
      life_short = shrt;
   endtask

   task automatic test_directed();
      logic [63:0] ka, kb, kc, kones;
      ka = 64'h0000_0100_0000_0005;
      kb = 64'h8000_0000_0000_0045;
      kc = 64'h1234_5678_9ABC_DE05;
      kones = '1;
      send_item(lpc_pkg::OP_PUT, '0, 10'd5, 32'h1);
      send_item(lpc_pkg::OP_GET, '0, '0, '0);
      send_item(lpc_pkg::OP_DELETE, '0, '0, '0);
      send_item(lpc_pkg::OP_PUT, ka, 10'd1001, 32'h2);
      send_item(lpc_pkg::OP_PUT, ka, 10'h3FF, 32'h2);
      send_item(lpc_pkg::OP_PUT, kones, lpc_pkg::SIGMA_MAX, '1);
      send_item(lpc_pkg::OP_PUT, ka, 10'd0, 32'h0);
      send_item(lpc_pkg::OP_PUT, kb, 10'd700, 32'hA5A5_5A5A);
      send_item(lpc_pkg::OP_PUT, kc, 10'd500, 32'h5A5A_A5A5);
      send_item(lpc_pkg::OP_GET, kb, '0, '0);
      send_item(lpc_pkg::OP_PUT, kb, 10'd800, 32'hDEAD_BEEF);
      send_item(lpc_pkg::OP_GET, kb, '0, '0);
      send_item(lpc_pkg::OP_GET, kones, '0, '0);
      send_item(lpc_pkg::OP_GET, 64'h0000_0000_0000_0045, '0, '0);
      send_item(lpc_pkg::OP_DELETE, ka, '0, '0);
      send_item(lpc_pkg::OP_GET, kc, '0, '0);
      send_item(lpc_pkg::OP_DELETE, ka, '0, '0);
      send_item(lpc_pkg::OP_SWEEP, '0, '0, '0);
      send_item(3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)), kc, '0, '0);
      repeat (12) send_item(lpc_pkg::OP_TICK, '0, '0, '0);
      // Entries with sigma above the threshold now exceed the short lifetime.
      send_item(lpc_pkg::OP_SWEEP, '0, '0, '0);
      send_item(lpc_pkg::OP_GET, kc, '0, '0);
      drain_results();
   endtask

   // More distinct keys than slots, so later puts must evict.
   task automatic test_fill_evict();
      logic [63:0] k;
      for (int n = 0; n < 72; n++) begin
         k = {$urandom, $urandom};
         if (k == '0) k = 64'h1;
         send_item(lpc_pkg::OP_PUT, k, 10'($urandom_range(0, 1000)), $urandom);
         if (n % 9 == 0) send_item(lpc_pkg::OP_GET, k, '0, '0);
         if (n % 11 == 0) send_item(lpc_pkg::OP_TICK, '0, '0, '0);
      end
      drain_results();
   endtask

   task automatic test_stall_pressure();
      pressure_on = 1'b1;
      for (int n = 0; n < 40; n++) send_item(lpc_pkg::OP_TICK, '0, '0, '0);
      drain_results();
      pressure_on = 1'b0;
   endtask

   task automatic random_item();
      int pick;
      logic [63:0] k;
      logic [2:0] op;
      pick = $urandom_range(99);
      if (pick < 30) op = lpc_pkg::OP_PUT;
      else if (pick < 56) op = lpc_pkg::OP_GET;
      else if (pick < 68) op = lpc_pkg::OP_DELETE;
      else if (pick < 88) op = lpc_pkg::OP_TICK;
      else if (pick < 97) op = lpc_pkg::OP_SWEEP;
      else op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      pick = $urandom_range(99);
      if (pick < 85) k = key_pool[$urandom_range(95)];
      else if (pick < 90) k = '0;
      else k = {$urandom, $urandom};
      send_item(op, k, 10'($urandom_range(0, 1023)), $urandom);
   endtask

   task automatic test_random();
      for (int n = 0; n < 96; n++) begin
         // Few home slots so clusters form and probing goes deep.
         key_pool[n] = {$urandom, $urandom} & ~64'h3F | 64'($urandom_range(0, 15));
         if (key_pool[n] == '0) key_pool[n] = 64'h40;
      end
      write_registers(10'd0, 32'd0, 32'd0);
      idle_on = 1'b0;
      repeat (100) random_item();
      idle_on = 1'b1;
      drain_results();
      write_registers(lpc_pkg::SIGMA_MAX, '1, '1);
      repeat (70) random_item();
      drain_results();
      write_registers(10'd500, 32'd8, 32'd20);
      repeat (70) random_item();
      drain_results();
      write_registers(lpc_pkg::TRUST_RESET, 32'd15, 32'd3);
      repeat (70) random_item();
      drain_results();
   endtask

   initial begin
      for (int i = 0; i < NSLOTS; i++) clear_entry(i);
      step_now = '0;
      trust_lim = lpc_pkg::TRUST_RESET;
      life_long = lpc_pkg::LONG_RESET;
      life_short = lpc_pkg::SHORT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_evict();
      test_stall_pressure();
      test_random();
      repeat (20) @(posedge clock);
      $display("Sent %0d items (put, get, delete, tick, sweep, rejects, unused types);",
               items_sent);
      $display("checked %0d results over four register settings and a full table.",
               results_seen);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
